>>> sv/projective_point_transform_core_macros.svh
`ifndef PROJECTIVE_POINT_TRANSFORM_CORE_MACROS_SVH
`define PROJECTIVE_POINT_TRANSFORM_CORE_MACROS_SVH

// same-cycle implication
`define PPT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ppt_pkg.sv
package ppt_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_WIDTH = 32;
    localparam int EPS_W       = 16;
    localparam int COEF_AW     = 4;
    localparam int NUM_COEFS   = 16;
    localparam int PROD_W      = 2 * COORD_WIDTH;
    localparam int SUM_W       = PROD_W + 2;
    localparam int QUO_W       = COORD_WIDTH + 1;
    localparam int DIV_LAT     = QUO_W + 2;
    localparam int FQ_DEPTH    = 4;
    localparam int FQ_AW       = $clog2(FQ_DEPTH);
    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(7);

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_XFORM = 1'b1
    } t_op;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [SUM_W-1:0]       t_sum;

    localparam t_coord COEF_ONE = t_coord'(1) <<< FRAC_BITS;
    localparam logic [SUM_W-1:0] W_ONE = SUM_W'(1) << (2 * FRAC_BITS);

    typedef struct packed {
        t_op                op;
        logic [COEF_AW-1:0] idx;
        t_coord             value;
        t_coord             x;
        t_coord             y;
        t_coord             z;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

endpackage

>>> sv/ppt_front.sv
module ppt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ppt_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output ppt_pkg::t_head o_head
);
    import ppt_pkg::*;

    t_item              r_mem [FQ_DEPTH];
    logic [FQ_AW-1:0]   r_wr_ptr;
    logic [FQ_AW-1:0]   r_rd_ptr;
    logic [FQ_AW:0]     r_count;
    logic               push_ok;
    logic               pop_ok;
    t_item              cls_item;

    assign o_full       = (r_count == (FQ_AW + 1)'(FQ_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd_ptr];
    assign push_ok      = i_push && !o_full;
    assign pop_ok       = i_pop && o_head.valid;

    // drop the fields that the item kind does not use
    always_comb begin
        cls_item = i_item;
        if (i_item.op == OP_LOAD) begin
            cls_item.x = '0;
            cls_item.y = '0;
            cls_item.z = '0;
        end else begin
            cls_item.idx   = '0;
            cls_item.value = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= cls_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> sv/ppt_dot.sv
module ppt_dot (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_take,
    input  ppt_pkg::t_item i_item,
    output logic           o_valid,
    output ppt_pkg::t_sum  o_sum [4]
);
    import ppt_pkg::*;

    t_coord                    r_coef [NUM_COEFS];
    logic signed [PROD_W-1:0]  r_prod [4][3];
    t_sum                      r_trans [4];
    t_sum                      r_pa [4];
    t_sum                      r_pb [4];
    t_sum                      r_sum [4];
    logic [2:0]                r_valid;
    t_coord                    pnt [3];

    assign pnt[0] = i_item.x;
    assign pnt[1] = i_item.y;
    assign pnt[2] = i_item.z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEFS; i++) begin
                r_coef[i] <= ((i % 5) == 0) ? COEF_ONE : '0;
            end
        end else if (i_take && i_item.op == OP_LOAD) begin
            r_coef[i_item.idx] <= i_item.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_adv) begin
            r_valid <= {r_valid[1:0], i_take && i_item.op == OP_XFORM};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[r][c] <= r_coef[r + 4 * c] * pnt[c];
                end
                r_trans[r] <= t_sum'(r_coef[r + 12]) <<< FRAC_BITS;
                r_pa[r]    <= t_sum'(r_prod[r][0]) + t_sum'(r_prod[r][1]);
                r_pb[r]    <= t_sum'(r_prod[r][2]) + r_trans[r];
                r_sum[r]   <= r_pa[r] + r_pb[r];
            end
        end
    end

    assign o_valid = r_valid[2];
    assign o_sum   = r_sum;

endmodule

>>> sv/ppt_div.sv
module ppt_div (
    input  logic                        i_clk,
    input  logic                        i_adv,
    input  ppt_pkg::t_sum               i_num,
    input  logic [ppt_pkg::SUM_W-1:0]   i_dmag,
    input  logic                        i_dneg,
    output ppt_pkg::t_coord             o_res,
    output logic                        o_sat
);
    import ppt_pkg::*;

    localparam int NW = SUM_W + FRAC_BITS;
    localparam int CW = SUM_W + QUO_W;
    localparam logic [QUO_W-1:0] LIMIT = QUO_W'(1) << (COORD_WIDTH - 1);

    logic [NW-1:0]    r_rem [QUO_W+1];
    logic [QUO_W-1:0] r_q   [QUO_W+1];
    logic [SUM_W-1:0] r_d   [QUO_W+1];
    logic             r_neg [QUO_W+1];
    logic             r_ovf [QUO_W+1];
    t_coord           r_res;
    logic             r_sat;
    logic [SUM_W-1:0] num_mag;
    logic [NW-1:0]    num_sh;
    logic [QUO_W-1:0] q_fin;
    logic [QUO_W-1:0] q_negd;

    assign num_mag = i_num[SUM_W-1] ? SUM_W'(-i_num) : SUM_W'(i_num);
    assign num_sh  = {num_mag, {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem[0] <= num_sh;
            r_q[0]   <= '0;
            r_d[0]   <= i_dmag;
            r_neg[0] <= i_num[SUM_W-1] ^ i_dneg;
            r_ovf[0] <= CW'(num_sh >> QUO_W) >= CW'(i_dmag);
        end
    end

    for (genvar s = 0; s < QUO_W; s++) begin : g_step
        localparam int B = QUO_W - 1 - s;
        logic [CW-1:0] trial;
        logic          fits;

        assign trial = CW'(r_d[s]) << B;
        assign fits  = CW'(r_rem[s]) >= trial;

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[s+1] <= fits ? r_rem[s] - trial[NW-1:0] : r_rem[s];
                r_q[s+1]   <= fits ? r_q[s] | (QUO_W'(1) << B) : r_q[s];
                r_d[s+1]   <= r_d[s];
                r_neg[s+1] <= r_neg[s];
                r_ovf[s+1] <= r_ovf[s];
            end
        end
    end

    assign q_fin  = r_q[QUO_W];
    assign q_negd = -q_fin;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (!r_neg[QUO_W]) begin
                if (r_ovf[QUO_W] || q_fin > LIMIT - 1'b1) begin
                    r_res <= t_coord'((LIMIT - 1'b1));
                    r_sat <= 1'b1;
                end else begin
                    r_res <= q_fin[COORD_WIDTH-1:0];
                    r_sat <= 1'b0;
                end
            end else begin
                if (r_ovf[QUO_W] || q_fin > LIMIT) begin
                    r_res <= LIMIT[COORD_WIDTH-1:0];
                    r_sat <= 1'b1;
                end else begin
                    r_res <= q_negd[COORD_WIDTH-1:0];
                    r_sat <= 1'b0;
                end
            end
        end
    end

    assign o_res = r_res;
    assign o_sat = r_sat;

endmodule

>>> sv/projective_point_transform_core.sv
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+------------------------------------
// input     | in        | push / full            | operation, coef_index, coef_value,
//           |           |                        | point_x, point_y, point_z
// result    | out       | empty / pop            | out_x, out_y, out_z, w_clamped, saturated
// config    | in        | i_cfg_we               | i_cfg_wdata (w_epsilon)
//
// One item per cycle sustained while results are popped; a transform result appears after its
// item leaves the 4-entry input queue and passes 3 dot-product stages, 1 w stage,
// 35 divider stages and 1 output register; a load yields no result.
// The divider yields one quotient bit per stage, over 33 stages.
// Synchronous active-low reset restores the identity matrix and epsilon 7.
// A result not popped stalls the back pipeline; the queue keeps taking items until full.
module projective_point_transform_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            i_operation,
    input  logic [ppt_pkg::COEF_AW-1:0]     i_coef_index,
    input  logic signed [ppt_pkg::COORD_WIDTH-1:0] i_coef_value,
    input  logic signed [ppt_pkg::COORD_WIDTH-1:0] i_point_x,
    input  logic signed [ppt_pkg::COORD_WIDTH-1:0] i_point_y,
    input  logic signed [ppt_pkg::COORD_WIDTH-1:0] i_point_z,
    output logic                            empty,
    input  logic                            pop,
    output logic signed [ppt_pkg::COORD_WIDTH-1:0] o_out_x,
    output logic signed [ppt_pkg::COORD_WIDTH-1:0] o_out_y,
    output logic signed [ppt_pkg::COORD_WIDTH-1:0] o_out_z,
    output logic                            o_w_clamped,
    output logic                            o_saturated,
    input  logic                            i_cfg_we,
    input  logic [ppt_pkg::EPS_W-1:0]       i_cfg_wdata
);
    import ppt_pkg::*;
    `include "projective_point_transform_core_macros.svh"

    logic [EPS_W-1:0]   r_eps;
    t_item              in_item;
    t_head              head;
    logic               adv;
    logic               take;
    logic               dot_valid;
    t_sum               dot_sum [4];

    logic               w_neg;
    logic [SUM_W-1:0]   w_mag;
    logic [SUM_W-1:0]   eps_sc;
    logic               w_clamp;

    logic               r_w_valid;
    t_sum               r_w_num [3];
    logic [SUM_W-1:0]   r_w_dmag;
    logic               r_w_dneg;
    logic               r_w_clamp;

    logic [DIV_LAT-1:0] r_v_pipe;
    logic [DIV_LAT-1:0] r_c_pipe;
    t_coord             div_res [3];
    logic [2:0]         div_sat;

    logic               r_out_valid;
    t_coord             r_out_x;
    t_coord             r_out_y;
    t_coord             r_out_z;
    logic               r_out_clamp;
    logic               r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    assign in_item.op    = t_op'(i_operation);
    assign in_item.idx   = i_coef_index;
    assign in_item.value = i_coef_value;
    assign in_item.x     = i_point_x;
    assign in_item.y     = i_point_y;
    assign in_item.z     = i_point_z;

    assign adv  = !r_out_valid || pop;
    assign take = adv && head.valid;

    ppt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (in_item),
        .o_full  (full),
        .i_pop   (take),
        .o_head  (head)
    );

    ppt_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_take  (take),
        .i_item  (head.item),
        .o_valid (dot_valid),
        .o_sum   (dot_sum)
    );

    assign w_neg   = dot_sum[3][SUM_W-1];
    assign w_mag   = w_neg ? SUM_W'(-dot_sum[3]) : SUM_W'(dot_sum[3]);
    assign eps_sc  = SUM_W'(r_eps) << FRAC_BITS;
    assign w_clamp = (w_mag < eps_sc) || (w_mag == '0);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_w_num[0] <= dot_sum[0];
            r_w_num[1] <= dot_sum[1];
            r_w_num[2] <= dot_sum[2];
            r_w_dmag   <= w_clamp ? W_ONE : w_mag;
            r_w_dneg   <= w_clamp ? 1'b0 : w_neg;
            r_w_clamp  <= w_clamp;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_div
        ppt_div u_div (
            .i_clk  (i_clk),
            .i_adv  (adv),
            .i_num  (r_w_num[k]),
            .i_dmag (r_w_dmag),
            .i_dneg (r_w_dneg),
            .o_res  (div_res[k]),
            .o_sat  (div_sat[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid   <= 1'b0;
            r_v_pipe    <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_w_valid   <= dot_valid;
            r_v_pipe    <= {r_v_pipe[DIV_LAT-2:0], r_w_valid};
            r_out_valid <= r_v_pipe[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_pipe    <= {r_c_pipe[DIV_LAT-2:0], r_w_clamp};
            r_out_x     <= div_res[0];
            r_out_y     <= div_res[1];
            r_out_z     <= div_res[2];
            r_out_clamp <= r_c_pipe[DIV_LAT-1];
            r_out_sat   <= |div_sat;
        end
    end

    assign empty       = !r_out_valid;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_out_z     = r_out_z;
    assign o_w_clamped = r_out_clamp;
    assign o_saturated = r_out_sat;

    `PPT_ASSERT_IMP(a_clamp_unit_w, r_w_valid && r_w_clamp, r_w_dmag == W_ONE && !r_w_dneg, "clamped w is not one")
    `PPT_ASSERT_NXT(a_stall_freeze, r_out_valid && !pop, $stable(r_v_pipe) && $stable(r_w_valid), "pipeline moved while stalled")
    `PPT_ASSERT_NXT(a_result_kept, r_out_valid && !pop, r_out_valid, "unpopped result lost")

endmodule

>>> tb/sv/testbench.sv
module testbench;
    import ppt_pkg::*;

    typedef struct {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   clamped;
        logic   sat;
    } t_point_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic i_operation = 1'b0;
    logic [COEF_AW-1:0] i_coef_index = '0;
    t_coord i_coef_value = '0;
    t_coord i_point_x = '0;
    t_coord i_point_y = '0;
    t_coord i_point_z = '0;
    logic empty;
    logic pop = 1'b0;
    t_coord o_out_x;
    t_coord o_out_y;
    t_coord o_out_z;
    logic o_w_clamped;
    logic o_saturated;
    logic i_cfg_we = 1'b0;
    logic [EPS_W-1:0] i_cfg_wdata = '0;

    t_item pending_items[$];
    t_point_result expected_points[$];
    t_coord matrix[NUM_COEFS];
    logic [EPS_W-1:0] epsilon;
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned cycles = 0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    int unsigned recv_hold = 0;
    bit hold_done = 0;
    bit send_burst = 0;
    bit recv_burst = 0;

    projective_point_transform_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_operation(i_operation), .i_coef_index(i_coef_index),
        .i_coef_value(i_coef_value), .i_point_x(i_point_x), .i_point_y(i_point_y),
        .i_point_z(i_point_z), .empty(empty), .pop(pop), .o_out_x(o_out_x),
        .o_out_y(o_out_y), .o_out_z(o_out_z), .o_w_clamped(o_w_clamped),
        .o_saturated(o_saturated), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic signed [127:0] row_dot(int row, t_coord px, t_coord py,
                                                    t_coord pz);
        logic signed [127:0] a, b, c, t, s;
        a = matrix[row];
        b = matrix[row + 4];
        c = matrix[row + 8];
        t = matrix[row + 12];
        s = a * px + b * py + c * pz + (t <<< FRAC_BITS);
        return s;
    endfunction

    function automatic t_coord divide_clip(logic signed [127:0] num, logic [127:0] wmag,
                                           logic wneg, inout logic sat);
        logic [127:0] mag, q;
        logic neg;
        neg = num[127] != wneg;
        mag = num[127] ? -num : num;
        q = (mag << FRAC_BITS) / wmag;
        if (!neg) begin
            if (q > 128'h7fff_ffff) begin
                sat = 1'b1;
                return 32'h7fff_ffff;
            end
            return q[31:0];
        end
        if (q > 128'h8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return -q[31:0];
    endfunction

    function automatic void apply_item(t_item it);
        logic signed [127:0] w;
        logic [127:0] wmag, eps_full;
        logic wneg;
        t_point_result r;
        if (it.op == OP_LOAD) begin
            matrix[it.idx] = it.value;
            return;
        end
        w = row_dot(3, it.x, it.y, it.z);
        wneg = w[127];
        wmag = wneg ? -w : w;
        eps_full = 128'(epsilon) << FRAC_BITS;
        r.clamped = (wmag < eps_full) || (wmag == 0);
        if (r.clamped) begin
            wmag = 128'd1 << (2 * FRAC_BITS);
            wneg = 1'b0;
        end
        r.sat = 1'b0;
        r.x = divide_clip(row_dot(0, it.x, it.y, it.z), wmag, wneg, r.sat);
        r.y = divide_clip(row_dot(1, it.x, it.y, it.z), wmag, wneg, r.sat);
        r.z = divide_clip(row_dot(2, it.x, it.y, it.z), wmag, wneg, r.sat);
        expected_points.push_back(r);
    endfunction

    function automatic int unsigned draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 16);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        int unsigned g;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && !full) begin
            apply_item(pending_items.pop_front());
            if ($urandom_range(0, 40) == 0) send_burst = ~send_burst;
            g = draw_gap(send_burst);
            if (g == 0 && pending_items.size() > 0) begin
                i_operation <= pending_items[0].op;
                i_coef_index <= pending_items[0].idx;
                i_coef_value <= pending_items[0].value;
                i_point_x <= pending_items[0].x;
                i_point_y <= pending_items[0].y;
                i_point_z <= pending_items[0].z;
            end else begin
                push <= 1'b0;
                send_wait <= g;
            end
        end else if (!push) begin
            if (send_wait > 0) begin
                send_wait <= send_wait - 1;
            end else if (pending_items.size() > 0) begin
                i_operation <= pending_items[0].op;
                i_coef_index <= pending_items[0].idx;
                i_coef_value <= pending_items[0].value;
                i_point_x <= pending_items[0].x;
                i_point_y <= pending_items[0].y;
                i_point_z <= pending_items[0].z;
                push <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_point_result e;
        int unsigned g;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (pop && !empty) begin
            results_seen <= results_seen + 1;
            if (expected_points.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result x=%h y=%h z=%h", o_out_x, o_out_y, o_out_z);
            end else begin
                e = expected_points.pop_front();
                if (o_out_x !== e.x || o_out_y !== e.y || o_out_z !== e.z
                        || o_w_clamped !== e.clamped || o_saturated !== e.sat) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: exp %h %h %h c%b s%b got %h %h %h c%b s%b",
                                 e.x, e.y, e.z, e.clamped, e.sat, o_out_x, o_out_y,
                                 o_out_z, o_w_clamped, o_saturated);
                end
            end
            if (!hold_done && results_seen == 100) begin
                hold_done <= 1'b1;
                recv_hold <= 600;
                pop <= 1'b0;
            end else begin
                if ($urandom_range(0, 40) == 0) recv_burst = ~recv_burst;
                g = draw_gap(recv_burst);
                if (g != 0) begin
                    pop <= 1'b0;
                    recv_wait <= g;
                end
            end
        end else if (!pop) begin
            if (recv_hold > 0) recv_hold <= recv_hold - 1;
            else if (recv_wait > 0) recv_wait <= recv_wait - 1;
            else pop <= 1'b1;
        end
    end

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return t_coord'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            2: begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return '0;
                    3: return 32'hffff_ffff;
                    default: return COEF_ONE;
                endcase
            end
            default: return t_coord'($signed($urandom_range(0, 32'h0400_0000))
                                     - 32'sh0200_0000);
        endcase
    endfunction

    function automatic void queue_load(int idx, t_coord v);
        t_item it;
        it = '0;
        it.op = OP_LOAD;
        it.idx = idx[COEF_AW-1:0];
        it.value = v;
        it.x = $urandom;
        it.y = $urandom;
        it.z = $urandom;
        pending_items.push_back(it);
    endfunction

    function automatic void queue_point(t_coord x, t_coord y, t_coord z);
        t_item it;
        it.op = OP_XFORM;
        it.idx = COEF_AW'($urandom);
        it.value = $urandom;
        it.x = x;
        it.y = y;
        it.z = z;
        pending_items.push_back(it);
    endfunction

    task automatic wait_idle();
        while (pending_items.size() > 0 || push || expected_points.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_epsilon(logic [EPS_W-1:0] v);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        epsilon = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [EPS_W-1:0] eps_set[4];
        for (int i = 0; i < NUM_COEFS; i++) matrix[i] = (i % 5 == 0) ? COEF_ONE : '0;
        epsilon = EPS_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_point(32'h0001_0000, 32'h0002_0000, 32'hfffd_0000);
        queue_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
        queue_load(0, 32'h7fff_ffff);
        queue_point(32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff);
        queue_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        queue_load(12, 32'h7fff_ffff);
        queue_load(13, 32'h8000_0000);
        queue_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        queue_load(15, 32'h0000_0000);
        queue_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        queue_load(3, 32'h8000_0000);
        queue_point(32'h0001_0000, 32'hffff_0000, 32'h0000_8000);
        queue_load(7, 32'h0000_0003);
        queue_load(3, 32'h0000_0000);
        queue_point(32'h0000_0000, 32'h0000_0001, 32'h0000_0000);
        queue_load(3, 32'h0000_4000);
        queue_point(32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
        queue_load(11, 32'hffff_fffe);
        queue_point(32'h0000_0000, 32'h0000_0000, 32'h0010_0000);

        write_epsilon(16'd0);
        for (int i = 0; i < NUM_COEFS; i++) queue_load(i, '0);
        queue_point(32'h1234_5678, 32'h8765_4321, 32'h0000_0000);

        eps_set[0] = 16'd0;
        eps_set[1] = 16'hffff;
        eps_set[2] = EPS_W'($urandom);
        eps_set[3] = EPS_RESET;
        for (int p = 0; p < 4; p++) begin
            write_epsilon(eps_set[p]);
            for (int i = 0; i < NUM_COEFS; i++)
                queue_load(i, (i % 5 == 0) ? COEF_ONE + $urandom_range(0, 32'h2_0000)
                                            : rand_coord());
            for (int n = 0; n < 220; n++) begin
                if ($urandom_range(0, 3) == 0) queue_load($urandom_range(0, 15), rand_coord());
                else queue_point(rand_coord(), rand_coord(), rand_coord());
            end
        end

        wait_idle();
        if (mismatches == 0 && expected_points.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
